// File: sv/olidf_pkg.sv
// Shared types and constants for the ordered list block.
package olidf_pkg;

	// Field widths fixed by the interface
	localparam int ACT_W  = 2;
	localparam int POS_W  = 7;
	localparam int DATA_W = 32;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_LOCATE = 2'd2;

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_INS_CHK,
		ST_INS_WR,
		ST_DEL_CAP,
		ST_DEL_CHK,
		ST_DEL_WR,
		ST_LOC_CHK,
		ST_LOC_CMP,
		ST_FINISH
	} state_t;

	// Walking index update
	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_COUNT,
		IDX_POS,
		IDX_ZERO,
		IDX_DEC,
		IDX_INC
	} idx_op_t;

	// Read address source
	typedef enum logic [1:0] {
		RD_IDX,
		RD_IDX_M1,
		RD_POS_M1
	} rd_sel_t;

	// Write address and data source
	typedef enum logic [1:0] {
		WR_IDX,
		WR_IDX_M1,
		WR_POS_M1
	} wr_sel_t;

	// Controller to datapath commands
	typedef struct packed {
		logic    load;
		idx_op_t idx_op;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    set_ok;
		logic    cap_taken;
		logic    set_where;
		logic    publish;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic             ins_ok;
		logic             del_ok;
		logic             ins_more;
		logic             idx_below_cnt;
		logic             match;
		logic             out_free;
	} sts_t;

endpackage

// File: sv/olidf_dpath.sv
// Datapath: list memory, length count, walking index, result and output registers.
module olidf_dpath #(
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic [olidf_pkg::ACT_W-1:0]             action,
	input  logic [olidf_pkg::POS_W-1:0]             position,
	input  logic signed [olidf_pkg::DATA_W-1:0]     value,
	input  olidf_pkg::cmd_t                         cmd,
	output olidf_pkg::sts_t                         sts,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic                                    ok,
	output logic signed [olidf_pkg::DATA_W-1:0]     removed_value,
	output logic [olidf_pkg::POS_W-1:0]             found_position,
	output logic [olidf_pkg::POS_W-1:0]             list_length
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = ((CW > olidf_pkg::POS_W) ? CW : olidf_pkg::POS_W) + 1;
	localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

	// List store
	logic [olidf_pkg::DATA_W-1:0] mem [DEPTH];
	logic [olidf_pkg::DATA_W-1:0] rd_data_q;

	// Transaction registers
	logic [olidf_pkg::ACT_W-1:0]         act_q;
	logic [olidf_pkg::POS_W-1:0]         pos_q;
	logic signed [olidf_pkg::DATA_W-1:0] val_q;
	logic [CW-1:0]                       idx_q;
	logic [CW-1:0]                       count_q;

	// Result registers
	logic                                ok_q;
	logic signed [olidf_pkg::DATA_W-1:0] taken_q;
	logic [olidf_pkg::POS_W-1:0]         where_q;

	// Output registers
	logic                                out_valid_q;
	logic                                out_ok_q;
	logic signed [olidf_pkg::DATA_W-1:0] out_taken_q;
	logic [olidf_pkg::POS_W-1:0]         out_where_q;
	logic [olidf_pkg::POS_W-1:0]         out_len_q;

	// Widened views for compares and address math
	logic [XW-1:0] pos_x;
	logic [XW-1:0] pos_m1_x;
	logic [XW-1:0] idx_x;
	logic [XW-1:0] idx_m1_x;
	logic [XW-1:0] idx_p1_x;
	logic [XW-1:0] count_x;
	logic [XW-1:0] count_p1_x;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [olidf_pkg::DATA_W-1:0] wr_data;

	assign pos_x      = XW'(pos_q);
	assign pos_m1_x   = pos_x - XW'(1);
	assign idx_x      = XW'(idx_q);
	assign idx_m1_x   = idx_x - XW'(1);
	assign idx_p1_x   = idx_x + XW'(1);
	assign count_x    = XW'(count_q);
	assign count_p1_x = count_x + XW'(1);

	// Status back to the controller
	always_comb begin
		sts.act           = act_q;
		sts.ins_ok        = (pos_x != '0) && (pos_x <= count_p1_x) && (count_x < DEPTH_X);
		sts.del_ok        = (pos_x != '0) && (pos_x <= count_x);
		sts.ins_more      = (idx_x >= pos_x);
		sts.idx_below_cnt = (idx_q < count_q);
		sts.match         = (rd_data_q == val_q);
		sts.out_free      = !out_valid_q || !out_stall;
	end

	// Address and data selection
	always_comb begin
		case (cmd.rd_sel)
			olidf_pkg::RD_IDX:    rd_addr = idx_x[AW-1:0];
			olidf_pkg::RD_IDX_M1: rd_addr = idx_m1_x[AW-1:0];
			olidf_pkg::RD_POS_M1: rd_addr = pos_m1_x[AW-1:0];
			default:              rd_addr = idx_x[AW-1:0];
		endcase
		case (cmd.wr_sel)
			olidf_pkg::WR_IDX: begin
				wr_addr = idx_x[AW-1:0];
				wr_data = rd_data_q;
			end
			olidf_pkg::WR_IDX_M1: begin
				wr_addr = idx_m1_x[AW-1:0];
				wr_data = rd_data_q;
			end
			olidf_pkg::WR_POS_M1: begin
				wr_addr = pos_m1_x[AW-1:0];
				wr_data = val_q;
			end
			default: begin
				wr_addr = idx_x[AW-1:0];
				wr_data = rd_data_q;
			end
		endcase
	end

	// Memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Transaction capture, walking index and results
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q   <= action;
			pos_q   <= position;
			val_q   <= value;
			ok_q    <= 1'b0;
			taken_q <= '0;
			where_q <= '0;
		end
		case (cmd.idx_op)
			olidf_pkg::IDX_COUNT: idx_q <= count_q;
			olidf_pkg::IDX_POS:   idx_q <= pos_x[CW-1:0];
			olidf_pkg::IDX_ZERO:  idx_q <= '0;
			olidf_pkg::IDX_DEC:   idx_q <= idx_m1_x[CW-1:0];
			olidf_pkg::IDX_INC:   idx_q <= idx_p1_x[CW-1:0];
			default:              idx_q <= idx_q;
		endcase
		if (cmd.set_ok || cmd.set_where) begin
			ok_q <= 1'b1;
		end
		if (cmd.cap_taken) begin
			taken_q <= rd_data_q;
		end
		if (cmd.set_where) begin
			where_q <= idx_p1_x[olidf_pkg::POS_W-1:0];
		end
	end

	// Length count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_inc) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.cnt_dec) begin
			count_q <= count_q - CW'(1);
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			out_ok_q    <= ok_q;
			out_taken_q <= taken_q;
			out_where_q <= where_q;
			out_len_q   <= count_x[olidf_pkg::POS_W-1:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign ok             = out_ok_q;
	assign removed_value  = out_taken_q;
	assign found_position = out_where_q;
	assign list_length    = out_len_q;

endmodule

// File: sv/olidf_ctrl.sv
// Controller: sequences insert, delete and locate over the list datapath.
module olidf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  olidf_pkg::sts_t sts,
	output olidf_pkg::cmd_t cmd
);

	olidf_pkg::state_t st_q;
	olidf_pkg::state_t st_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= olidf_pkg::ST_IDLE;
		end else begin
			st_q <= st_nxt;
		end
	end

	// Next state
	always_comb begin
		st_nxt = st_q;
		case (st_q)
			olidf_pkg::ST_IDLE: begin
				if (in_valid) st_nxt = olidf_pkg::ST_DISPATCH;
			end
			olidf_pkg::ST_DISPATCH: begin
				case (sts.act)
					olidf_pkg::ACT_INSERT:
						st_nxt = sts.ins_ok ? olidf_pkg::ST_INS_CHK : olidf_pkg::ST_FINISH;
					olidf_pkg::ACT_DELETE:
						st_nxt = sts.del_ok ? olidf_pkg::ST_DEL_CAP : olidf_pkg::ST_FINISH;
					olidf_pkg::ACT_LOCATE:
						st_nxt = olidf_pkg::ST_LOC_CHK;
					default:
						st_nxt = olidf_pkg::ST_FINISH;
				endcase
			end
			olidf_pkg::ST_INS_CHK: begin
				st_nxt = sts.ins_more ? olidf_pkg::ST_INS_WR : olidf_pkg::ST_FINISH;
			end
			olidf_pkg::ST_INS_WR:  st_nxt = olidf_pkg::ST_INS_CHK;
			olidf_pkg::ST_DEL_CAP: st_nxt = olidf_pkg::ST_DEL_CHK;
			olidf_pkg::ST_DEL_CHK: begin
				st_nxt = sts.idx_below_cnt ? olidf_pkg::ST_DEL_WR : olidf_pkg::ST_FINISH;
			end
			olidf_pkg::ST_DEL_WR:  st_nxt = olidf_pkg::ST_DEL_CHK;
			olidf_pkg::ST_LOC_CHK: begin
				st_nxt = sts.idx_below_cnt ? olidf_pkg::ST_LOC_CMP : olidf_pkg::ST_FINISH;
			end
			olidf_pkg::ST_LOC_CMP: begin
				st_nxt = sts.match ? olidf_pkg::ST_FINISH : olidf_pkg::ST_LOC_CHK;
			end
			olidf_pkg::ST_FINISH: begin
				if (sts.out_free) st_nxt = olidf_pkg::ST_IDLE;
			end
			default: st_nxt = olidf_pkg::ST_IDLE;
		endcase
	end

	// Command outputs
	always_comb begin
		cmd        = '0;
		cmd.idx_op = olidf_pkg::IDX_HOLD;
		cmd.rd_sel = olidf_pkg::RD_IDX;
		cmd.wr_sel = olidf_pkg::WR_IDX;
		in_stall   = 1'b1;
		case (st_q)
			olidf_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			olidf_pkg::ST_DISPATCH: begin
				case (sts.act)
					olidf_pkg::ACT_INSERT: cmd.idx_op = olidf_pkg::IDX_COUNT;
					olidf_pkg::ACT_DELETE: begin
						// fetch the entry being removed
						cmd.idx_op = olidf_pkg::IDX_POS;
						cmd.rd_en  = sts.del_ok;
						cmd.rd_sel = olidf_pkg::RD_POS_M1;
					end
					olidf_pkg::ACT_LOCATE: cmd.idx_op = olidf_pkg::IDX_ZERO;
					default:               cmd.idx_op = olidf_pkg::IDX_HOLD;
				endcase
			end
			olidf_pkg::ST_INS_CHK: begin
				if (sts.ins_more) begin
					// read entry below the hole
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = olidf_pkg::RD_IDX_M1;
				end else begin
					// drop the new value into the hole
					cmd.wr_en   = 1'b1;
					cmd.wr_sel  = olidf_pkg::WR_POS_M1;
					cmd.cnt_inc = 1'b1;
					cmd.set_ok  = 1'b1;
				end
			end
			olidf_pkg::ST_INS_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = olidf_pkg::WR_IDX;
				cmd.idx_op = olidf_pkg::IDX_DEC;
			end
			olidf_pkg::ST_DEL_CAP: cmd.cap_taken = 1'b1;
			olidf_pkg::ST_DEL_CHK: begin
				if (sts.idx_below_cnt) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = olidf_pkg::RD_IDX;
				end else begin
					cmd.cnt_dec = 1'b1;
					cmd.set_ok  = 1'b1;
				end
			end
			olidf_pkg::ST_DEL_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = olidf_pkg::WR_IDX_M1;
				cmd.idx_op = olidf_pkg::IDX_INC;
			end
			olidf_pkg::ST_LOC_CHK: begin
				cmd.rd_en  = sts.idx_below_cnt;
				cmd.rd_sel = olidf_pkg::RD_IDX;
			end
			olidf_pkg::ST_LOC_CMP: begin
				if (sts.match) begin
					cmd.set_where = 1'b1;
				end else begin
					cmd.idx_op = olidf_pkg::IDX_INC;
				end
			end
			olidf_pkg::ST_FINISH: cmd.publish = sts.out_free;
			default: cmd.load = 1'b0;
		endcase
	end

endmodule

// File: sv/ordered_list_insert_delete_find.sv
// Top level of the ordered list block: insert, delete and locate on a stored list.
//
//   channel | handshake          | payload
//   --------+--------------------+--------------------------------------------------
//   in      | in_valid/in_stall  | action, position, value
//   out     | out_valid/out_stall| ok, removed_value, found_position, list_length
//
// One transaction at a time. An insert moves each entry from the end down to its position one
// place toward the end and then writes the new value; a delete captures the removed entry and
// moves each later entry one place toward the front; a locate scans from the first entry until
// a match or the end; a rejected insert or delete or an unused action goes straight to the result.
// Each moved entry is read and then written back; each scanned entry is read and then compared.
// Reset clears the length and the controller; list contents are undefined until written.
// A new transaction is taken while a finished result waits under out_stall; the next result
// then holds in the controller, with the input stalled, until the output register frees.
module ordered_list_insert_delete_find #(
	parameter int DEPTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [olidf_pkg::ACT_W-1:0]         action,
	input  logic [olidf_pkg::POS_W-1:0]         position,
	input  logic signed [olidf_pkg::DATA_W-1:0] value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                ok,
	output logic signed [olidf_pkg::DATA_W-1:0] removed_value,
	output logic [olidf_pkg::POS_W-1:0]         found_position,
	output logic [olidf_pkg::POS_W-1:0]         list_length
);

	olidf_pkg::cmd_t cmd;
	olidf_pkg::sts_t sts;

	olidf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	olidf_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.action         (action),
		.position       (position),
		.value          (value),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.ok             (ok),
		.removed_value  (removed_value),
		.found_position (found_position),
		.list_length    (list_length)
	);

`ifndef ASSERT_OFF
	// Result is only loaded when the output register is free
	a_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (!out_valid || !out_stall))
		else $error("result loaded over a pending result");

	// An accepted transaction keeps the input stalled on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after accept");

	// Length never moves both ways at once
	a_count_one_way: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.cnt_inc && cmd.cnt_dec))
		else $error("length incremented and decremented together");

	// A fresh result only appears after the controller published it
	a_out_from_publish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.publish))
		else $error("output valid without publish");
`endif

endmodule

// File: test/ordered_list_insert_delete_find_tb.sv
// Self-checking testbench for the ordered list block: insert, delete and locate.
module ordered_list_insert_delete_find_tb;

	localparam int LIST_DEPTH     = 64;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES    = 160;
	localparam int HOLD_CYCLES    = 400;
	localparam int MAX_PRINTED    = 30;

	// Action code that the block leaves unused
	localparam logic [olidf_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

	localparam logic signed [olidf_pkg::DATA_W-1:0] VAL_MIN = 32'h8000_0000;
	localparam logic signed [olidf_pkg::DATA_W-1:0] VAL_MAX = 32'h7fff_ffff;

	// Weighting modes for the random part
	localparam int MIX_GROW    = 0;
	localparam int MIX_SHRINK  = 1;
	localparam int MIX_BALANCE = 2;
	localparam int MIX_FILL    = 3;

	typedef struct packed {
		logic                                ok;
		logic signed [olidf_pkg::DATA_W-1:0] removed;
		logic [olidf_pkg::POS_W-1:0]         where;
		logic [olidf_pkg::POS_W-1:0]         len;
	} list_result_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                in_valid = 1'b0;
	logic                                in_stall;
	logic [olidf_pkg::ACT_W-1:0]         action = '0;
	logic [olidf_pkg::POS_W-1:0]         position = '0;
	logic signed [olidf_pkg::DATA_W-1:0] value = '0;
	logic                                out_valid;
	logic                                out_stall = 1'b0;
	logic                                ok;
	logic signed [olidf_pkg::DATA_W-1:0] removed_value;
	logic [olidf_pkg::POS_W-1:0]         found_position;
	logic [olidf_pkg::POS_W-1:0]         list_length;

	// Shadow copy of the list
	logic signed [olidf_pkg::DATA_W-1:0] list_mem [LIST_DEPTH];
	int                                  list_len = 0;

	list_result_t expected_q [$];

	int  err_count = 0;
	int  results_checked = 0;
	int  sent_count = 0;
	int  full_hits = 0;
	int  empty_hits = 0;
	int  idle_cycles = 0;
	bit  send_idle = 1'b1;
	bit  recv_idle = 1'b1;
	int  stall_hold_req = 0;
	int  stall_hold_left = 0;
	int  stall_burst_left = 0;

	ordered_list_insert_delete_find #(
		.DEPTH(LIST_DEPTH)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.position      (position),
		.value         (value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.ok            (ok),
		.removed_value (removed_value),
		.found_position(found_position),
		.list_length   (list_length)
	);

	always #10 clk = ~clk;

	// Apply one action to the shadow list and return the result it should give
	function automatic list_result_t apply_action(input logic [olidf_pkg::ACT_W-1:0] act,
			input logic [olidf_pkg::POS_W-1:0] pos,
			input logic signed [olidf_pkg::DATA_W-1:0] val);
		list_result_t r;
		int           p;
		int           j;
		r = '0;
		p = int'(pos);
		case (act)
			olidf_pkg::ACT_INSERT: begin
				if (p >= 1 && p <= list_len + 1 && list_len < LIST_DEPTH) begin
					for (j = list_len; j >= p; j--)
						list_mem[j] = list_mem[j - 1];
					list_mem[p - 1] = val;
					list_len++;
					r.ok = 1'b1;
				end
			end
			olidf_pkg::ACT_DELETE: begin
				if (p >= 1 && p <= list_len) begin
					r.removed = list_mem[p - 1];
					for (j = p; j < list_len; j++)
						list_mem[j - 1] = list_mem[j];
					list_len--;
					r.ok = 1'b1;
				end
			end
			olidf_pkg::ACT_LOCATE: begin
				for (j = 0; j < list_len; j++)
					if (r.where == '0 && list_mem[j] == val)
						r.where = olidf_pkg::POS_W'(j + 1);
				r.ok = (r.where != '0);
			end
			default: ;
		endcase
		r.len = olidf_pkg::POS_W'(list_len);
		return r;
	endfunction

	// Value source: small pool for duplicates, extremes, full range, or a stored entry
	function automatic logic signed [olidf_pkg::DATA_W-1:0] pick_value(input bit from_list);
		int                                  r;
		logic signed [olidf_pkg::DATA_W-1:0] v;
		r = $urandom_range(0, 9);
		if (from_list && list_len > 0 && r < 6) begin
			v = list_mem[$urandom_range(0, list_len - 1)];
		end else if (r < 3) begin
			v = $urandom_range(0, 15);
			v = v - 8;
		end else if (r == 3) begin
			case ($urandom_range(0, 3))
				0: v = VAL_MIN;
				1: v = VAL_MAX;
				2: v = '0;
				default: v = -1;
			endcase
		end else begin
			v = $urandom();
		end
		return v;
	endfunction

	// Mostly legal positions, with zero, one past the legal end and raw 7-bit values mixed in
	function automatic logic [olidf_pkg::POS_W-1:0] pick_insert_pos();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return olidf_pkg::POS_W'(list_len + 2);
			2: return olidf_pkg::POS_W'($urandom_range(0, 127));
			3: return olidf_pkg::POS_W'(list_len + 1);
			default: return olidf_pkg::POS_W'($urandom_range(1, list_len + 1));
		endcase
	endfunction

	function automatic logic [olidf_pkg::POS_W-1:0] pick_delete_pos();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return olidf_pkg::POS_W'(list_len + 1);
			2: return olidf_pkg::POS_W'($urandom_range(0, 127));
			default: return (list_len > 0) ? olidf_pkg::POS_W'($urandom_range(1, list_len))
				: olidf_pkg::POS_W'(1);
		endcase
	endfunction

	function automatic logic [olidf_pkg::ACT_W-1:0] choose_action(input int mode);
		int roll;
		int ins_w;
		int del_w;
		roll = $urandom_range(0, 99);
		case (mode)
			MIX_GROW: begin
				ins_w = 62;
				del_w = 18;
			end
			MIX_SHRINK: begin
				ins_w = 18;
				del_w = 62;
			end
			default: begin
				ins_w = 40;
				del_w = 40;
			end
		endcase
		if (roll < 3)
			return ACT_UNUSED;
		else if (roll < 3 + ins_w)
			return olidf_pkg::ACT_INSERT;
		else if (roll < 3 + ins_w + del_w)
			return olidf_pkg::ACT_DELETE;
		return olidf_pkg::ACT_LOCATE;
	endfunction

	task automatic report_mismatch(input string what,
			input logic [olidf_pkg::DATA_W-1:0] got,
			input logic [olidf_pkg::DATA_W-1:0] want);
		err_count++;
		if (err_count <= MAX_PRINTED)
			$display("mismatch at %0t: %s got %h, expected %h", $time, what, got, want);
	endtask

	// Offer one transaction, wait for acceptance, then record its expected result
	task automatic send_item(input logic [olidf_pkg::ACT_W-1:0] act,
			input logic [olidf_pkg::POS_W-1:0] pos,
			input logic signed [olidf_pkg::DATA_W-1:0] val);
		list_result_t want;
		if (send_idle && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		position <= pos;
		value    <= val;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		if (act == olidf_pkg::ACT_INSERT && list_len == LIST_DEPTH)
			full_hits++;
		want = apply_action(act, pos, val);
		if (act == olidf_pkg::ACT_DELETE && want.ok && list_len == 0)
			empty_hits++;
		expected_q.push_back(want);
		sent_count++;
	endtask

	// Stop offering and wait until every expected result has come back
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (expected_q.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic send_random(input logic [olidf_pkg::ACT_W-1:0] act);
		case (act)
			olidf_pkg::ACT_INSERT: send_item(act, pick_insert_pos(), pick_value(1'b0));
			olidf_pkg::ACT_DELETE: send_item(act, pick_delete_pos(), pick_value(1'b0));
			default: send_item(act, olidf_pkg::POS_W'($urandom_range(0, 127)),
				pick_value(1'b1));
		endcase
	endtask

	// Empty list: every delete fails, locate finds nothing
	task automatic test_empty_list();
		send_item(olidf_pkg::ACT_DELETE, 7'd1, 32'sd5);
		send_item(olidf_pkg::ACT_DELETE, 7'd0, 32'sd0);
		send_item(olidf_pkg::ACT_LOCATE, 7'd0, 32'sd0);
		send_item(ACT_UNUSED, 7'd127, -32'sd1);
	endtask

	// Insert at the edges of the legal position range
	task automatic test_insert_edges();
		send_item(olidf_pkg::ACT_INSERT, 7'd0, 32'sd11);
		send_item(olidf_pkg::ACT_INSERT, 7'd2, 32'sd12);
		send_item(olidf_pkg::ACT_INSERT, 7'd1, VAL_MIN);
		send_item(olidf_pkg::ACT_INSERT, 7'd2, VAL_MAX);
		send_item(olidf_pkg::ACT_INSERT, 7'd1, 32'sd0);
		send_item(olidf_pkg::ACT_INSERT, 7'd4, -32'sd1);
		send_item(olidf_pkg::ACT_INSERT, 7'd127, 32'sd13);
		send_item(olidf_pkg::ACT_INSERT, 7'd6, 32'sd14);
	endtask

	// Locate returns the first of duplicate entries, zero when absent
	task automatic test_locate_first();
		send_item(olidf_pkg::ACT_INSERT, 7'd5, VAL_MAX);
		send_item(olidf_pkg::ACT_LOCATE, 7'd127, VAL_MAX);
		send_item(olidf_pkg::ACT_LOCATE, 7'd0, VAL_MIN);
		send_item(olidf_pkg::ACT_LOCATE, 7'd3, 32'sd12345);
	endtask

	// Delete past the end, at the last, first and a middle position
	task automatic test_delete_edges();
		send_item(olidf_pkg::ACT_DELETE, 7'd6, 32'sd0);
		send_item(olidf_pkg::ACT_DELETE, 7'd127, 32'sd0);
		send_item(olidf_pkg::ACT_DELETE, 7'd5, 32'sd0);
		send_item(olidf_pkg::ACT_DELETE, 7'd1, 32'sd0);
		send_item(olidf_pkg::ACT_DELETE, 7'd2, 32'sd0);
	endtask

	task automatic test_unused_action();
		send_item(ACT_UNUSED, 7'd1, VAL_MAX);
		send_item(ACT_UNUSED, 7'd0, 32'sd0);
	endtask

	// Fill to capacity, then hit the full-list rejects and edits at the top
	task automatic test_full_list();
		while (list_len < LIST_DEPTH)
			send_item(olidf_pkg::ACT_INSERT,
				olidf_pkg::POS_W'($urandom_range(1, list_len + 1)), pick_value(1'b0));
		send_item(olidf_pkg::ACT_INSERT, 7'd1, 32'sd1);
		send_item(olidf_pkg::ACT_INSERT, olidf_pkg::POS_W'(LIST_DEPTH + 1), 32'sd2);
		send_item(olidf_pkg::ACT_LOCATE, 7'd0, list_mem[LIST_DEPTH - 1]);
		send_item(olidf_pkg::ACT_DELETE, olidf_pkg::POS_W'(LIST_DEPTH), 32'sd0);
		send_item(olidf_pkg::ACT_INSERT, olidf_pkg::POS_W'(LIST_DEPTH), VAL_MIN);
		send_item(olidf_pkg::ACT_DELETE, olidf_pkg::POS_W'(LIST_DEPTH + 1), 32'sd0);
	endtask

	// Receiver holds off long enough for the block to stall its input
	task automatic test_backpressure();
		int k;
		@(negedge clk);
		stall_hold_req = HOLD_CYCLES;
		@(posedge clk);
		for (k = 0; k < 12; k++)
			send_random(choose_action(MIX_BALANCE));
		wait_results_drained();
	endtask

	// Random segments that grow, shrink, churn or fill the list
	task automatic test_random_mix(input int n_items);
		int done;
		int seg_len;
		int mode;
		int k;
		done = 0;
		while (done < n_items) begin
			mode = $urandom_range(MIX_GROW, MIX_FILL);
			seg_len = (mode == MIX_FILL) ? 80 : $urandom_range(15, 60);
			for (k = 0; k < seg_len && done < n_items; k++) begin
				if (mode == MIX_FILL && list_len < LIST_DEPTH)
					send_item(olidf_pkg::ACT_INSERT,
						olidf_pkg::POS_W'($urandom_range(1, list_len + 1)),
						pick_value(1'b0));
				else
					send_random(choose_action(mode));
				done++;
			end
		end
	endtask

	// Receiver: long hold-offs on request, otherwise random stall bursts
	always @(posedge clk) begin
		if (stall_hold_req > 0) begin
			stall_hold_left = stall_hold_req;
			stall_hold_req = 0;
		end
		if (stall_hold_left > 0) begin
			stall_hold_left--;
			out_stall <= 1'b1;
		end else if (stall_burst_left > 0) begin
			stall_burst_left--;
			out_stall <= 1'b1;
		end else if (recv_idle && $urandom_range(0, 5) == 0) begin
			stall_burst_left = $urandom_range(1, 7) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Compare each accepted result with the oldest pending expectation
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			results_checked++;
			if (expected_q.size() == 0) begin
				report_mismatch("result with none pending", '0, '0);
			end else begin
				want = expected_q.pop_front();
				if (ok !== want.ok)
					report_mismatch("ok", olidf_pkg::DATA_W'(ok),
						olidf_pkg::DATA_W'(want.ok));
				if (removed_value !== want.removed)
					report_mismatch("removed_value", removed_value, want.removed);
				if (found_position !== want.where)
					report_mismatch("found_position", olidf_pkg::DATA_W'(found_position),
						olidf_pkg::DATA_W'(want.where));
				if (list_length !== want.len)
					report_mismatch("list_length", olidf_pkg::DATA_W'(list_length),
						olidf_pkg::DATA_W'(want.len));
			end
		end
	end

	// Watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_insert_edges();
		test_locate_first();
		test_delete_edges();
		test_unused_action();
		wait_results_drained();
		test_full_list();
		wait_results_drained();
		test_backpressure();
		test_random_mix(500);
		wait_results_drained();

		// Last part runs at full rate on both sides
		send_idle = 1'b0;
		recv_idle = 1'b0;
		test_random_mix(520);
		wait_results_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d transactions and checked %0d results across directed and random mixes.",
			sent_count, results_checked);
		$display("Inserts into a full list: %0d, deletes that emptied the list: %0d.",
			full_hits, empty_hits);
		if (err_count == 0 && expected_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
